>>> hw/rtl/ipc_pkg.sv
package ipc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CUBE_B,
        ST_CUBE_S,
        ST_PRIME_GO,
        ST_PRIME_WAIT
    } ipc_state_t;

endpackage

>>> hw/rtl/ipc_divider.sv
module ipc_divider #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH:0]   trial;
    logic             fits;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[WIDTH-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = WIDTH'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/integer_property_classifier.sv
// channel  direction  transfer when         signals
// command  in         start && !busy        number
// result   out        done (one cycle)      is_prime, is_even, is_square, is_cube
//
// one number at a time: load, (W-1)/2+1 square root steps, then (W+2)/3 cube root digits,
// each a ST_CUBE_B and a ST_CUBE_S step, then one divider run per trial division
// worst case is a prime just below 2^(W-1): about sqrt(2^(W-1))/2 divisions
// on the serial divider
// rst_n clears the sequencer asynchronously; the result strobe cannot be stalled
module integer_property_classifier #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] number,
    output logic                         done,
    output logic                         is_prime,
    output logic                         is_even,
    output logic                         is_square,
    output logic                         is_cube
);
    import ipc_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int TOPB  = ((W - 1) / 2) * 2;
    localparam int S0    = ((W - 1) / 3) * 3;
    localparam int YW    = (W + 2) / 3;
    localparam int BW    = 2 * YW + 3;
    localparam int CW    = (BW > W) ? BW : W;
    localparam int SW    = $clog2(S0 + 1);

    ipc_state_t state_reg, state_next;

    logic          done_reg, done_next;
    logic          prime_reg, prime_next;
    logic          even_reg, even_next;
    logic          sq_reg, sq_next;
    logic          cube_reg, cube_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  mag_reg, mag_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  root_reg, root_next;
    logic [W-1:0]  bit_reg, bit_next;
    logic [YW-1:0] y_reg, y_next;
    logic [BW-1:0] b_reg, b_next;
    logic [SW-1:0] s_reg, s_next;
    logic [W-1:0]  d_reg, d_next;
    logic          div_go;

    logic              div_done;
    logic [W-1:0]      div_quo;
    logic [W-1:0]      div_rem;
    logic [W:0]        sq_sum;
    logic [YW-1:0]     y2;
    logic [2*YW:0]     prod;
    logic [CW-1:0]     rem_shr;
    logic [CW-1:0]     b_shl;
    logic [W-1:0]      in_mag;

    ipc_divider #(
        .WIDTH (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (mag_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        in_mag  = number[W-1] ? W'(-number) : W'(number);
        sq_sum  = {1'b0, root_reg} + {1'b0, bit_reg};
        y2      = {y_reg[YW-2:0], 1'b0};
        prod    = (2*YW+1)'(y2) * (2*YW+1)'({1'b0, y2} + 1'b1);
        rem_shr = CW'(rem_reg) >> s_reg;
        b_shl   = CW'(b_reg) << s_reg;

        state_next = state_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        even_next  = even_reg;
        sq_next    = sq_reg;
        cube_next  = cube_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        y_next     = y_reg;
        b_next     = b_reg;
        s_next     = s_reg;
        d_next     = d_reg;
        div_go     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next   = number[W-1];
                    mag_next   = in_mag;
                    even_next  = !number[0];
                    rem_next   = in_mag;
                    root_next  = '0;
                    bit_next   = W'(1) << TOPB;
                    state_next = ST_SQRT;
                end
            end

            // square root digit recurrence, two bits of the radicand a step
            ST_SQRT:
            begin
                if ({1'b0, rem_reg} >= sq_sum)
                begin
                    rem_next  = W'({1'b0, rem_reg} - sq_sum);
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    sq_next    = !neg_reg && (rem_next == '0);
                    rem_next   = mag_reg;
                    y_next     = '0;
                    s_next     = SW'(S0);
                    state_next = ST_CUBE_B;
                end
            end

            // next trial term 3y(y+1)+1 for the cube root digit
            ST_CUBE_B:
            begin
                y_next     = y2;
                b_next     = BW'({prod, 1'b0}) + BW'(prod) + BW'(1);
                state_next = ST_CUBE_S;
            end

            ST_CUBE_S:
            begin
                if (rem_shr >= CW'(b_reg))
                begin
                    rem_next = rem_reg - b_shl[W-1:0];
                    y_next   = y_reg + 1'b1;
                end
                if (s_reg == '0)
                begin
                    cube_next = (rem_next == '0);
                    d_next    = W'(3);
                    if (neg_reg || (mag_reg < W'(2)))
                    begin
                        prime_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (!mag_reg[0])
                    begin
                        prime_next = (mag_reg == W'(2));
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PRIME_GO;
                    end
                end
                else
                begin
                    s_next     = SW'(s_reg - SW'(3));
                    state_next = ST_CUBE_B;
                end
            end

            ST_PRIME_GO:
            begin
                div_go     = 1'b1;
                state_next = ST_PRIME_WAIT;
            end

            // quotient below the divisor means the divisor passed the root
            ST_PRIME_WAIT:
            begin
                if (div_done)
                begin
                    if (div_quo < d_reg)
                    begin
                        prime_next = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (div_rem == '0)
                    begin
                        prime_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + W'(2);
                        state_next = ST_PRIME_GO;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        even_reg  <= even_next;
        sq_reg    <= sq_next;
        cube_reg  <= cube_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        y_reg     <= y_next;
        b_reg     <= b_next;
        s_reg     <= s_next;
        d_reg     <= d_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign is_prime  = prime_reg;
    assign is_even   = even_reg;
    assign is_square = sq_reg;
    assign is_cube   = cube_reg;

endmodule

>>> tb/integer_property_classifier_tb.sv
module integer_property_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     W            = 32;
    localparam int     CLK_HALF     = 6;
    localparam int     RANDOM_ITEMS = 75;
    localparam int     MAX_GAP      = 12;
    localparam int     TAIL_CYCLES  = 20;
    localparam longint CYCLE_LIMIT  = 20_000_000;

    typedef struct packed {
        logic prime;
        logic even;
        logic square;
        logic cube;
    } flags_t;

    class flags_scoreboard;
        flags_t expected_flags[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        function automatic flags_t classify(logic signed [W-1:0] n);
            flags_t          f;
            longint unsigned m;
            longint unsigned d;
            longint unsigned r;
            longint unsigned c;
            longint unsigned t;
            f.even  = ~n[0];
            // magnitude in 64 bits, so the most negative value does not overflow
            m       = n[W-1] ? longint'(-longint'(n)) : longint'(n);
            f.prime = 1'b0;
            if (!n[W-1] && m >= 2)
            begin
                if (m[0] == 1'b0)
                begin
                    f.prime = (m == 2);
                end
                else
                begin
                    f.prime = 1'b1;
                    d = 3;
                    while (f.prime && d * d <= m)
                    begin
                        if (m % d == 0)
                            f.prime = 1'b0;
                        d += 2;
                    end
                end
            end
            // roots built one bit at a time from the top
            r = 0;
            for (int b = 16; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= m)
                    r = t;
            end
            f.square = !n[W-1] && (r * r == m);
            c = 0;
            for (int b = 11; b >= 0; b--)
            begin
                t = c | (64'd1 << b);
                if (t * t * t <= m)
                    c = t;
            end
            f.cube = (c * c * c == m);
            return f;
        endfunction

        function void note_number(logic signed [W-1:0] n);
            expected_flags.push_back(classify(n));
        endfunction

        function void compare_flag(string name, logic want, logic got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_flags(flags_t got);
            flags_t want;
            if (expected_flags.size() == 0)
            begin
                $display("%0t: result with no number outstanding, expected none, actual %b",
                         $time, got);
                errors++;
                return;
            end
            want = expected_flags.pop_front();
            compare_flag("is_prime", want.prime, got.prime);
            compare_flag("is_even", want.even, got.even);
            compare_flag("is_square", want.square, got.square);
            compare_flag("is_cube", want.cube, got.cube);
        endfunction

        function int outstanding();
            return expected_flags.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic signed [W-1:0] number;
    logic                done;
    logic                is_prime;
    logic                is_even;
    logic                is_square;
    logic                is_cube;

    flags_scoreboard board;
    logic            no_idle;
    longint          cycles;

    integer_property_classifier #(
        .DATA_WIDTH(W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .number   (number),
        .done     (done),
        .is_prime (is_prime),
        .is_even  (is_even),
        .is_square(is_square),
        .is_cube  (is_cube)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_flags('{is_prime, is_even, is_square, is_cube});
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.outstanding());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // start stays high straight into the next transfer when there is no gap
    task automatic send_number(input logic signed [W-1:0] n);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        number <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_number(n);
    endtask

    // magnitudes kept mostly small, since trial division time grows with the root
    function automatic logic signed [W-1:0] random_number();
        longint v;
        longint k;
        int     offset;
        offset = int'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = longint'($urandom_range(0, 8191)) - 4096;
            4, 5:
            begin
                k = $urandom_range(0, 2000);
                v = k * k + ($urandom_range(0, 1) ? 0 : offset);
            end
            6:
            begin
                // c^3 +/- 1 always has a factor near c, so it stays quick
                k = $urandom_range(0, 1290);
                v = k * k * k + ($urandom_range(0, 1) ? 0 : offset);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            7:
            begin
                v = $urandom_range(0, 1 << 20);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            8: v = longint'($urandom & 32'hffff_fffe);
            default:
            begin
                v = 3 * longint'($urandom_range(0, 715827882));
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v[W-1:0];
    endfunction

    int directed_numbers[25] = '{
        0, 1, 2, 3, 4, -1, -2, 8, -8, -27, 9, 15, 25, 64, -64, 97, 65537, 1000000,
        32'sh7fff_ffff, 32'sh8000_0000, -2147483645, 2147395600, 2146689000,
        -2141700569, 2147483646
    };

    initial
    begin
        board   = new();
        cycles  = 0;
        no_idle = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        number  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_numbers[i])
            send_number(directed_numbers[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 16 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_number(random_number());
        end
        start <= 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
